/* rtl/bts_pkg.sv */
`default_nettype none

package bts_pkg;

    // Field and register widths
    localparam int SAMPLE_W      = 24;
    localparam int WIN_W         = 7;
    localparam int LEN_W         = 17;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 17;

    // Storage sizes
    localparam int MAX_WINDOW    = 64;
    localparam int MAX_TRACE_LEN = 65536;
    localparam int ADDR_W        = $clog2(MAX_WINDOW);
    localparam int IDX_W         = $clog2(MAX_TRACE_LEN);
    localparam int HALF_W        = $clog2(MAX_WINDOW / 2 + 1);

    // Running sum of up to MAX_WINDOW samples and its magnitude
    localparam int SUM_W         = SAMPLE_W + ADDR_W + 1;
    localparam int MAG_W         = SUM_W - 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_LEN  = 2'd1;

    // Divider request and response
    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [WIN_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] quotient;
    } t_div_rsp;

    // Window length clamped to 1..MAX_WINDOW
    function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] r;
        r = w;
        if (w == '0) r = WIN_W'(1);
        else if (w > WIN_W'(MAX_WINDOW)) r = WIN_W'(MAX_WINDOW);
        return r;
    endfunction

    // Trace length clamped to 1..MAX_TRACE_LEN
    function automatic logic [LEN_W-1:0] eff_trace(input logic [LEN_W-1:0] l);
        logic [LEN_W-1:0] r;
        r = l;
        if (l == '0) r = LEN_W'(1);
        else if (l > LEN_W'(MAX_TRACE_LEN)) r = LEN_W'(MAX_TRACE_LEN);
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/bts_div.sv */
`default_nettype none

// Restoring divider: signed sum by unsigned window length, truncated toward zero.
// One quotient bit per cycle.
module bts_div
    import bts_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(MAG_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WIN_W-1:0] r_rem;
    logic [MAG_W-1:0] r_q;
    logic [WIN_W-1:0] r_d;
    logic             r_neg;

    logic [SUM_W-1:0] mag_full;
    logic [WIN_W:0]   trial;
    logic             fits;
    logic [MAG_W-1:0] q_signed;

    // Magnitude of the dividend and the trial subtraction
    always_comb begin
        mag_full = i_req.dividend[SUM_W-1] ? (~i_req.dividend + SUM_W'(1))
                                           : i_req.dividend;
        trial    = {r_rem, r_q[MAG_W-1]};
        fits     = trial >= {1'b0, r_d};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= mag_full[MAG_W-1:0];
            r_d   <= i_req.divisor;
            r_neg <= i_req.dividend[SUM_W-1];
        end else if (r_busy) begin
            r_rem <= fits ? WIN_W'(trial - {1'b0, r_d}) : trial[WIN_W-1:0];
            r_q   <= {r_q[MAG_W-2:0], fits};
        end
    end

    // Restore the sign
    assign q_signed       = r_neg ? (~r_q + MAG_W'(1)) : r_q;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = q_signed[SAMPLE_W-1:0];

endmodule

`default_nettype wire

/* rtl/boxcar_trace_smoother.sv */
`default_nettype none

// Boxcar smoother for one trace of 24-bit signed samples.
// Input stream (i_s_*): one sample per transfer. Output stream (o_m_*): one
// result per transfer, tlast marks the last output sample of a trace.
// Configuration: i_cfg_we with i_cfg_idx selects window_len (0) or trace_len
// (1); any write to either restarts the trace. Write only while idle.
// A sample is taken in the idle state only; the sequencer then updates the
// running sum and the 64-entry delay memory and builds its results one by one.
// A smoothed result runs through the shared serial divider before it is loaded
// into the output register; a passed-through result is read back from the
// delay memory. The final sample of a trace flushes up to window_len/2
// passed-through results. Early samples of a trace give no result.
// A stalled receiver holds the output register; the sequencer waits for it
// before loading the next result, and input is not taken until all results
// of the current sample are loaded.
// Reset: window_len 3, trace_len 1024, trace restarted, output empty. The
// delay memory needs no clearing: only entries of the current trace are read.
module boxcar_trace_smoother
    import bts_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [SAMPLE_W-1:0]   i_s_tdata,   // [23:0] sample
    // output stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [SAMPLE_W-1:0]        o_m_tdata,   // [23:0] result
    output logic                       o_m_tlast    // trace_end
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GONE = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_PUT  = 3'd5;

    logic [2:0]                 r_state;
    logic [WIN_W-1:0]           r_win;
    logic [LEN_W-1:0]           r_len;
    logic [IDX_W-1:0]           r_idx;
    logic [IDX_W-1:0]           r_i;
    logic                       r_last;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0]        r_val;
    logic [SAMPLE_W-1:0]        r_rd;
    logic                       r_out_valid;
    logic [SAMPLE_W-1:0]        r_out_data;
    logic                       r_out_last;

    logic [SAMPLE_W-1:0]        mem [MAX_WINDOW];

    logic [WIN_W-1:0]           w_eff;
    logic [HALF_W-1:0]          half;
    logic [WIN_W-1:0]           span;
    logic [HALF_W-1:0]          lat;
    logic [LEN_W-1:0]           len_eff;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       in_xfer;
    logic                       out_free;
    logic                       use_div;
    logic                       more;
    logic signed [SUM_W-1:0]    gone;
    t_div_req                   div_req;
    t_div_rsp                   div_rsp;

    // Window geometry from the configuration
    always_comb begin
        w_eff   = eff_window(r_win);
        half    = HALF_W'(w_eff >> 1);
        span    = {w_eff[WIN_W-1:1], 1'b0};
        lat     = (half != '0) ? half - HALF_W'(1) : '0;
        len_eff = eff_trace(r_len);
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    // Sample leaving the window, known only from the current trace
    assign gone = ({1'b0, r_idx} >= LEN_W'(span)) ? SUM_W'($signed(r_rd)) : '0;

    // Smoothed value only where the whole window lies inside the trace
    assign use_div = ({1'b0, r_i} >= LEN_W'(half)) &&
                     (({1'b0, r_i} + LEN_W'(half)) < len_eff);
    assign more    = r_last && (r_i != r_idx);

    // Delay memory read address: leaving sample while idle, output sample otherwise
    assign rd_addr = (r_state == S_IDLE) ? (r_idx[ADDR_W-1:0] - span[ADDR_W-1:0])
                                         : r_i[ADDR_W-1:0];

    // Delay memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_GONE) mem[r_idx[ADDR_W-1:0]] <= r_x;
        r_rd <= mem[rd_addr];
    end

    // Divider
    assign div_req.start    = (r_state == S_SEL) && use_div;
    assign div_req.dividend = r_sum;
    assign div_req.divisor  = w_eff;

    bts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sequencer, trace position and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_win   <= WIN_W'(3);
            r_len   <= LEN_W'(1024);
            r_idx   <= '0;
            r_sum   <= '0;
            r_i     <= '0;
            r_last  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_we && (i_cfg_idx == CFG_WINDOW_LEN ||
                                     i_cfg_idx == CFG_TRACE_LEN)) begin
                        if (i_cfg_idx == CFG_WINDOW_LEN) r_win <= i_cfg_data[WIN_W-1:0];
                        else r_len <= i_cfg_data[LEN_W-1:0];
                        r_idx <= '0;
                        r_sum <= '0;
                    end else if (in_xfer) begin
                        r_last  <= ({1'b0, r_idx} + LEN_W'(1)) >= len_eff;
                        r_state <= S_GONE;
                    end
                end
                S_GONE: begin
                    if (span != '0) r_sum <= r_sum + SUM_W'(r_x) - gone;
                    if (r_idx >= IDX_W'(lat)) begin
                        r_i     <= r_idx - IDX_W'(lat);
                        r_state <= S_SEL;
                    end else if (r_last) begin
                        r_i     <= '0;
                        r_state <= S_SEL;
                    end else begin
                        // nothing ready yet
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_IDLE;
                    end
                end
                S_SEL: begin
                    r_state <= use_div ? S_DIV : S_RD;
                end
                S_RD: begin
                    r_state <= S_PUT;
                end
                S_DIV: begin
                    if (div_rsp.done) r_state <= S_PUT;
                end
                S_PUT: begin
                    if (out_free) begin
                        if (more) begin
                            r_i     <= r_i + IDX_W'(1);
                            r_state <= S_SEL;
                        end else begin
                            if (r_last) begin
                                r_idx <= '0;
                                r_sum <= '0;
                            end else begin
                                r_idx <= r_idx + IDX_W'(1);
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Sample and result value capture
    always_ff @(posedge i_clk) begin
        if (in_xfer) r_x <= $signed(i_s_tdata);
        if (r_state == S_RD) r_val <= r_rd;
        else if (r_state == S_DIV && div_rsp.done) r_val <= div_rsp.quotient;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_PUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUT && out_free) begin
            r_out_data <= r_val;
            r_out_last <= ({1'b0, r_i} + LEN_W'(1)) == len_eff;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

/* rtl/bts_chk.sv */
`default_nettype none

module bts_chk
    import bts_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_s_tvalid,
    input wire logic                o_s_tready,
    input wire logic                o_m_tvalid,
    input wire logic                i_m_tready,
    input wire logic [SAMPLE_W-1:0] o_m_tdata,
    input wire logic                o_m_tlast
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled result changed");

    // Only one sample in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while a sample is in work");

    // Reset empties the output and leaves the block ready
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("reset did not clear the block");

    // A transfer out never follows directly after an input transfer with a new result
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !o_m_tvalid) |=> !o_m_tvalid)
        else $error("result appeared without processing time");

endmodule

bind boxcar_trace_smoother bts_chk u_bts_chk (.*);

`default_nettype wire
